>>> rtl/ptpq_pkg.sv
// Package for the periodic task priority queue.
// Holds the task word layout, command and status codes and the control bundle.
// Used by ptpq_cell and periodic_task_priority_queue_top; depends on nothing.
package ptpq_pkg;

  localparam int unsigned QUEUE_DEPTH = 16;

  localparam logic CMD_INSERT   = 1'b0;
  localparam logic CMD_DISPATCH = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [15:0] id;
    logic [7:0]  prio;
    logic [15:0] exec_time;
    logic [15:0] period;
  } task_t;

  // Broadcast to every cell of the chain.
  typedef struct packed {
    logic  ins;     // insert the task word into its sorted place
    logic  deq;     // remove the head, every cell takes its right neighbor
    logic  req;     // with deq: reinsert the removed head in the same cycle
    task_t entry;   // new task, or the head when it is reinserted
  } ctl_t;

endpackage

>>> rtl/periodic_task_priority_queue_top.sv
// Top level of the periodic task priority queue: handshake, occupancy count,
// result register and the chain of ptpq_cell slots. Depends on ptpq_pkg.
//
// Channel   Dir  Bus fields
// s_axis    in   tuser: command; tdata: task_id, task_priority, exec_time, task_period
// m_axis    out  tuser: status; tdata: out_id, out_priority, out_exec_time,
//                out_period, requeued, occupancy
//
// All slots compare against the broadcast task and shift in parallel, so a word
// is accepted each cycle while the result register is free or being drained.
// A stalled result holds the input side.
// Reset clears only the count and the result valid; slot contents need no
// clearing pass because slots at or beyond the count are never read.
module periodic_task_priority_queue_top #(
  parameter int unsigned QueueDepth = ptpq_pkg::QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [15:0] task_id, [23:16] task_priority, [39:24] exec_time, [55:40] task_period
  input  logic [55:0] s_axis_tdata_i,
  // [0] command
  input  logic        s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [15:0] out_id, [23:16] out_priority, [39:24] out_exec_time, [55:40] out_period,
  // [56] requeued, [61:57] occupancy, [63:62] zero
  output logic [63:0] m_axis_tdata_o,
  // [1:0] status
  output logic [1:0]  m_axis_tuser_o
);

  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  logic [CntW-1:0] count_q, count_d;
  logic            out_valid_q;
  logic [63:0]     out_data_q, out_data_d;
  logic [1:0]      out_status_q, out_status_d;

  logic            accept;
  logic            full, empty;
  ptpq_pkg::ctl_t  ctl;
  ptpq_pkg::task_t in_task, head, res_task;
  logic            res_req;
  logic [1:0]      res_status;

  ptpq_pkg::task_t cell_q  [QueueDepth];
  logic            cell_ge [QueueDepth];
  logic [QueueDepth-1:0] occ;

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign full            = (count_q == CntW'(QueueDepth));
  assign empty           = (count_q == '0);
  assign head            = cell_q[0];

  assign in_task.id        = s_axis_tdata_i[15:0];
  assign in_task.prio      = s_axis_tdata_i[23:16];
  assign in_task.exec_time = s_axis_tdata_i[39:24];
  assign in_task.period    = s_axis_tdata_i[55:40];

  always_comb begin
    ctl        = '0;
    res_task   = '0;
    res_req    = 1'b0;
    res_status = ptpq_pkg::ST_OK;
    count_d    = count_q;
    if (s_axis_tuser_i == ptpq_pkg::CMD_INSERT) begin
      ctl.entry = in_task;
      if (full) begin
        res_status = ptpq_pkg::ST_FULL;
      end else begin
        ctl.ins = accept;
        count_d = count_q + CntW'(1);
      end
    end else begin
      ctl.entry = head;
      if (empty) begin
        res_status = ptpq_pkg::ST_EMPTY;
      end else begin
        ctl.deq  = accept;
        res_task = head;
        res_req  = (head.period != '0);
        ctl.req  = accept && res_req;
        if (!res_req) begin
          count_d = count_q - CntW'(1);
        end
      end
    end
  end

  always_comb begin
    out_data_d          = '0;
    out_data_d[15:0]    = res_task.id;
    out_data_d[23:16]   = res_task.prio;
    out_data_d[39:24]   = res_task.exec_time;
    out_data_d[55:40]   = res_task.period;
    out_data_d[56]      = res_req;
    out_data_d[61:57]   = 5'(count_d);
    out_status_d        = res_status;
  end

  for (genvar i = 0; i < QueueDepth; i++) begin : g_cell
    assign occ[i] = (CntW'(i) < count_q);

    ptpq_pkg::task_t left, right;
    logic            occ_right, left_ge;

    if (i == 0) begin : g_first
      assign left    = '0;
      assign left_ge = 1'b1;
    end else begin : g_mid
      assign left    = cell_q[i-1];
      assign left_ge = cell_ge[i-1];
    end

    if (i == QueueDepth - 1) begin : g_last
      assign right     = '0;
      assign occ_right = 1'b0;
    end else begin : g_body
      assign right     = cell_q[i+1];
      assign occ_right = occ[i+1];
    end

    ptpq_cell u_cell (
      .clk_i       (clk_i),
      .ctl_i       (ctl),
      .occ_self_i  (occ[i]),
      .occ_right_i (occ_right),
      .left_i      (left),
      .right_i     (right),
      .left_ge_i   (left_ge),
      .entry_o     (cell_q[i]),
      .ge_o        (cell_ge[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q   <= out_data_d;
      out_status_q <= out_status_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_status_q;

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(QueueDepth))
    else $error("task count exceeds queue depth");

  a_accept_gives_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> m_axis_tvalid_o)
    else $error("accepted word produced no result");

  a_head_sorted : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q >= CntW'(2)) |-> (cell_q[0].prio >= cell_q[1].prio))
    else $error("head slots out of priority order");

  a_requeue_ok : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tdata_o[56]) |-> (m_axis_tuser_o == ptpq_pkg::ST_OK))
    else $error("requeue flagged on a failed command");

  a_full_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && full && (s_axis_tuser_i == ptpq_pkg::CMD_INSERT)) |=> $stable(count_q))
    else $error("insert into full queue changed the count");

endmodule

>>> rtl/ptpq_cell.sv
// One slot of the sorted task chain.
// Holds one task word and trades it with its left and right neighbors.
// Depends on ptpq_pkg.
module ptpq_cell (
  input  logic           clk_i,
  input  ptpq_pkg::ctl_t ctl_i,
  input  logic           occ_self_i,   // this slot holds a task
  input  logic           occ_right_i,  // the right neighbor holds a task
  input  ptpq_pkg::task_t left_i,
  input  ptpq_pkg::task_t right_i,
  input  logic           left_ge_i,    // left neighbor stays ahead of the new task
  output ptpq_pkg::task_t entry_o,
  output logic           ge_o
);

  ptpq_pkg::task_t entry_q, entry_d;

  // During a requeue the chain is viewed as already shifted left, so the
  // compare looks at the right neighbor's word.
  always_comb begin
    if (ctl_i.req) begin
      ge_o = occ_right_i && (right_i.prio >= ctl_i.entry.prio);
    end else begin
      ge_o = occ_self_i && (entry_q.prio >= ctl_i.entry.prio);
    end
  end

  always_comb begin
    entry_d = entry_q;
    if (ctl_i.ins) begin
      if (ge_o) begin
        entry_d = entry_q;
      end else if (left_ge_i) begin
        entry_d = ctl_i.entry;
      end else begin
        entry_d = left_i;
      end
    end else if (ctl_i.deq && ctl_i.req) begin
      if (ge_o) begin
        entry_d = right_i;
      end else if (left_ge_i) begin
        entry_d = ctl_i.entry;
      end else begin
        entry_d = entry_q;
      end
    end else if (ctl_i.deq) begin
      entry_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule
